// ===== rtl/dual_stack_vm_core_macros.svh =====
// Assertion macros used by the verification checker of the dual stack VM core.
// No dependencies.
`ifndef DUAL_STACK_VM_CORE_MACROS_SVH
`define DUAL_STACK_VM_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DSVM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DSVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dsvm_pkg.sv =====
// Shared types, sizes, opcodes and fault codes of the dual stack VM core.
// No dependencies.
package dsvm_pkg;

   localparam int CELL_BITS    = 32;
   localparam int MEM_WORDS    = 16384;
   localparam int MEM_AW       = $clog2(MEM_WORDS);
   localparam int DS_DEPTH     = 32;
   localparam int DS_AW        = $clog2(DS_DEPTH);
   localparam int RS_DEPTH     = 128;
   localparam int RS_AW        = $clog2(RS_DEPTH);
   localparam int DIV_CNT_BITS = $clog2(CELL_BITS);
   localparam int LAST_OP      = 26;
   localparam int REQ_BITS     = 48;
   localparam int RSP_BITS     = 72;

   typedef logic [CELL_BITS-1:0] cell_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LIT, OP_DUP, OP_DROP, OP_SWAP, OP_PUSH, OP_POP, OP_JUMP, OP_CALL,
      OP_IF, OP_RET, OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_FETCH, OP_STORE, OP_ADD,
      OP_SUB, OP_MUL, OP_DIVMOD, OP_AND, OP_OR, OP_XOR, OP_SHIFT, OP_ZRET, OP_END
   } opcode_type;

   typedef enum logic [2:0] {
      FLT_NONE, FLT_DATA_UNDER, FLT_DATA_OVER, FLT_RET_UNDER, FLT_RET_OVER,
      FLT_BAD_OP, FLT_DIV_ZERO, FLT_BAD_ADDR
   } fault_type;

   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] load_value;
      logic [13:0] load_address;
   } req_word_type;

   typedef struct packed {
      logic [4:0]       pad;
      fault_type        fault;
      logic             halted;
      logic [RS_AW-1:0] return_depth;
      logic [DS_AW-1:0] data_depth;
      logic [31:0]      top_value;
      logic [4:0]       executed_opcode;
      logic [13:0]      program_counter;
   } rsp_word_type;

   function automatic logic [1:0] need_cells(input opcode_type op);
      logic [1:0] n;
      case (op) inside
         OP_DUP, OP_DROP, OP_PUSH, OP_JUMP, OP_CALL, OP_FETCH, OP_ZRET: n = 2'd1;
         OP_SWAP, [OP_EQ:OP_GT], [OP_STORE:OP_XOR]:                  n = 2'd2;
         OP_IF:                                                       n = 2'd3;
         default:                                                     n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic grows(input opcode_type op);
      return (op == OP_LIT) || (op == OP_DUP) || (op == OP_POP);
   endfunction

   function automatic logic addr_ok(input cell_type v);
      return v < CELL_BITS'(MEM_WORDS);
   endfunction

endpackage

// ===== rtl/dsvm_alu.sv =====
// Combinational compare, add, subtract, multiply and logic unit of the VM core.
// Depends on dsvm_pkg.
module dsvm_alu (
   input  dsvm_pkg::opcode_type op,
   input  dsvm_pkg::cell_type   n,
   input  dsvm_pkg::cell_type   t,
   output dsvm_pkg::cell_type   result
);
   import dsvm_pkg::*;

   always_comb begin
      case (op)
         OP_EQ:   result = (n == t) ? '1 : '0;
         OP_NEQ:  result = (n != t) ? '1 : '0;
         OP_LT:   result = ($signed(n) < $signed(t)) ? '1 : '0;
         OP_GT:   result = ($signed(t) < $signed(n)) ? '1 : '0;
         OP_ADD:  result = n + t;
         OP_SUB:  result = n - t;
         OP_MUL:  result = n * t;
         OP_AND:  result = n & t;
         OP_OR:   result = n | t;
         OP_XOR:  result = n ^ t;
         default: result = '0;
      endcase
   end

endmodule

// ===== rtl/dsvm_div.sv =====
// Iterative signed divider giving a truncated quotient and remainder, one bit a cycle.
// Depends on dsvm_pkg.
module dsvm_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dsvm_pkg::cell_type dividend,
   input  dsvm_pkg::cell_type divisor,
   output logic               done,
   output dsvm_pkg::cell_type quotient,
   output dsvm_pkg::cell_type remainder
);
   import dsvm_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   cell_type                quo_ff;
   cell_type                rem_ff;
   cell_type                div_ff;
   logic                    neg_q_ff;
   logic                    neg_r_ff;
   logic [CELL_BITS:0]      trial_in;

   assign trial_in = {rem_ff, quo_ff[CELL_BITS-1]} - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= DIV_CNT_BITS'(CELL_BITS - 1);
            quo_ff   <= dividend[CELL_BITS-1] ? -dividend : dividend;
            div_ff   <= divisor[CELL_BITS-1] ? -divisor : divisor;
            rem_ff   <= '0;
            neg_q_ff <= dividend[CELL_BITS-1] ^ divisor[CELL_BITS-1];
            neg_r_ff <= dividend[CELL_BITS-1];
         end else if (busy_ff) begin
            if (trial_in[CELL_BITS]) begin
               rem_ff <= {rem_ff[CELL_BITS-2:0], quo_ff[CELL_BITS-1]};
            end else begin
               rem_ff <= trial_in[CELL_BITS-1:0];
            end
            quo_ff <= {quo_ff[CELL_BITS-2:0], ~trial_in[CELL_BITS]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? -quo_ff : quo_ff;
   assign remainder = neg_r_ff ? -rem_ff : rem_ff;

endmodule

// ===== rtl/dual_stack_vm_core.sv =====
// Top level of the dual stack VM core: memories, sequencer and stream ports.
// Depends on dsvm_pkg, dsvm_alu and dsvm_div.
// Load words pass S_TOP and S_DONE; step words first S_FETCH, S_DECODE, S_EXEC and S_WR1.
// Swap adds S_WR2, divmod also S_DIV for the bit-serial divider; words are taken in idle.
// The sequencer reads program memory and both stacks over registered read ports.
// After reset the program memory is cleared word by word before any word is accepted.
module dual_stack_vm_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // load_address [13:0], load_value [45:14], zero fill up to 47.
   input  logic [dsvm_pkg::REQ_BITS-1:0]    req_tdata,
   // kind [0].
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // program_counter [13:0], executed_opcode [18:14], top_value [50:19], data_depth [55:51],
   // return_depth [62:56], halted [63], fault [66:64], zero fill up to 71.
   output logic [dsvm_pkg::RSP_BITS-1:0]    rsp_tdata
);
   import dsvm_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_DIV, S_WR1, S_WR2, S_TOP, S_DONE
   } state_type;

   typedef struct packed {
      logic [DS_AW-1:0]  sp;
      logic [RS_AW-1:0]  rp;
      logic [MEM_AW-1:0] pc;
      logic              stop;
      fault_type         fault;
      logic              ds0_we;
      logic [DS_AW-1:0]  ds0_a;
      cell_type          ds0_d;
      logic              ds1_we;
      logic [DS_AW-1:0]  ds1_a;
      cell_type          ds1_d;
      logic              rs_we;
      logic [RS_AW-1:0]  rs_a;
      cell_type          rs_d;
      logic              pm_we;
      logic [MEM_AW-1:0] pm_a;
      cell_type          pm_d;
   } commit_type;

   cell_type pm_mem [MEM_WORDS];
   cell_type ds_mem [DS_DEPTH];
   cell_type rs_mem [RS_DEPTH];

   state_type         state_ff;
   logic [MEM_AW-1:0] clr_cnt_ff;
   logic [MEM_AW-1:0] pc_ff;
   logic [DS_AW-1:0]  sp_ff;
   logic [RS_AW-1:0]  rp_ff;
   logic              stop_ff;
   fault_type         fault_ff;
   logic [4:0]        rep_op_ff;
   cell_type          w_ff;
   cell_type          t_ff;
   cell_type          n_ff;
   cell_type          r_ff;
   commit_type        cm_ff;
   commit_type        cm_in;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;

   cell_type          pm_q_ff;
   cell_type          ds_q0_ff;
   cell_type          ds_q1_ff;
   cell_type          rs_q_ff;

   logic              pm_we;
   logic [MEM_AW-1:0] pm_wa;
   cell_type          pm_wd;
   logic              pm_re;
   logic [MEM_AW-1:0] pm_ra;
   logic              ds_we;
   logic [DS_AW-1:0]  ds_wa;
   cell_type          ds_wd;
   logic              ds_re0;
   logic              ds_re1;
   logic [DS_AW-1:0]  ds_ra0;
   logic [DS_AW-1:0]  ds_ra1;

   req_word_type      req_word;
   logic              req_fire;
   cell_type          t_dec;
   opcode_type        op;
   cell_type          alu_res;
   cell_type          if_target;
   cell_type          ret_target;
   fault_type         flt;
   logic [MEM_AW:0]   nxt;
   logic              end_hit;
   logic              div_go;
   logic              div_done;
   cell_type          div_quo;
   cell_type          div_rem;

   assign req_word   = req_word_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_word_ff);

   assign t_dec = (sp_ff != '0) ? ds_q0_ff : '0;
   assign op    = opcode_type'(w_ff[4:0]);

   dsvm_alu u_alu (
      .op     (op),
      .n      (n_ff),
      .t      (t_ff),
      .result (alu_res)
   );

   dsvm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (n_ff),
      .divisor   (t_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      pm_we = 1'b0;
      pm_wa = pm_ra;
      pm_wd = '0;
      if (state_ff == S_CLEAR) begin
         pm_we = 1'b1;
         pm_wa = clr_cnt_ff;
      end else if (req_fire && !req_tuser[0]) begin
         pm_we = 1'b1;
         pm_wa = MEM_AW'(req_word.load_address);
         pm_wd = CELL_BITS'(signed'(req_word.load_value));
      end else if (state_ff == S_WR1 && cm_ff.pm_we) begin
         pm_we = 1'b1;
         pm_wa = cm_ff.pm_a;
         pm_wd = cm_ff.pm_d;
      end
   end

   always_comb begin
      pm_re = 1'b0;
      pm_ra = pc_ff;
      if (state_ff == S_FETCH) begin
         pm_re = 1'b1;
      end else if (state_ff == S_DECODE) begin
         pm_re = 1'b1;
         if (pm_q_ff == CELL_BITS'(OP_LIT)) begin
            pm_ra = pc_ff + 1'b1;
         end else begin
            pm_ra = t_dec[MEM_AW-1:0];
         end
      end
   end

   always_comb begin
      ds_we  = 1'b0;
      ds_wa  = cm_ff.ds0_a;
      ds_wd  = cm_ff.ds0_d;
      if (state_ff == S_WR1) begin
         ds_we = cm_ff.ds0_we;
      end else if (state_ff == S_WR2) begin
         ds_we = cm_ff.ds1_we;
         ds_wa = cm_ff.ds1_a;
         ds_wd = cm_ff.ds1_d;
      end
      ds_re0 = (state_ff == S_FETCH) || (state_ff == S_TOP);
      ds_re1 = (state_ff == S_FETCH) || (state_ff == S_DECODE);
      ds_ra0 = sp_ff;
      ds_ra1 = (state_ff == S_DECODE) ? sp_ff - DS_AW'(2) : sp_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pm_mem[pm_wa] <= pm_wd;
      end
      if (pm_re) begin
         pm_q_ff <= pm_mem[pm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ds_we) begin
         ds_mem[ds_wa] <= ds_wd;
      end
      if (ds_re0) begin
         ds_q0_ff <= ds_mem[ds_ra0];
      end
      if (ds_re1) begin
         ds_q1_ff <= ds_mem[ds_ra1];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WR1 && cm_ff.rs_we) begin
         rs_mem[cm_ff.rs_a] <= cm_ff.rs_d;
      end
      if (state_ff == S_FETCH) begin
         rs_q_ff <= rs_mem[rp_ff];
      end
   end

   // The third cell from the top arrives from the second stack port during execute.
   assign if_target  = (ds_q1_ff != '0) ? n_ff : t_ff;
   assign ret_target = r_ff + 1'b1;

   always_comb begin
      cm_in       = '0;
      cm_in.sp    = sp_ff;
      cm_in.rp    = rp_ff;
      cm_in.pc    = pc_ff;
      cm_in.stop  = stop_ff;
      cm_in.fault = fault_ff;
      flt         = FLT_NONE;
      nxt         = {1'b0, pc_ff} + 1'b1;
      end_hit     = 1'b0;
      div_go      = 1'b0;
      if (w_ff > CELL_BITS'(LAST_OP)) begin
         flt = FLT_BAD_OP;
      end else if (sp_ff < DS_AW'(need_cells(op))) begin
         flt = FLT_DATA_UNDER;
      end else if (grows(op) && sp_ff == DS_AW'(DS_DEPTH - 1)) begin
         flt = FLT_DATA_OVER;
      end else if ((op == OP_POP || op == OP_RET) && rp_ff == '0) begin
         flt = FLT_RET_UNDER;
      end else if ((op == OP_PUSH || op == OP_CALL || op == OP_IF)
                   && rp_ff == RS_AW'(RS_DEPTH - 1)) begin
         flt = FLT_RET_OVER;
      end else begin
         case (op)
            OP_LIT: begin
               if (pc_ff == MEM_AW'(MEM_WORDS - 1)) begin
                  flt = FLT_BAD_ADDR;
               end else begin
                  cm_in.ds0_we = 1'b1;
                  cm_in.ds0_a  = sp_ff + 1'b1;
                  cm_in.ds0_d  = pm_q_ff;
                  cm_in.sp     = sp_ff + 1'b1;
                  nxt          = nxt + 1'b1;
               end
            end
            OP_DUP: begin
               cm_in.ds0_we = 1'b1;
               cm_in.ds0_a  = sp_ff + 1'b1;
               cm_in.ds0_d  = t_ff;
               cm_in.sp     = sp_ff + 1'b1;
            end
            OP_DROP: begin
               cm_in.sp = sp_ff - 1'b1;
            end
            OP_SWAP: begin
               cm_in.ds0_we = 1'b1;
               cm_in.ds0_a  = sp_ff;
               cm_in.ds0_d  = n_ff;
               cm_in.ds1_we = 1'b1;
               cm_in.ds1_a  = sp_ff - 1'b1;
               cm_in.ds1_d  = t_ff;
            end
            OP_PUSH: begin
               cm_in.rs_we = 1'b1;
               cm_in.rs_a  = rp_ff + 1'b1;
               cm_in.rs_d  = t_ff;
               cm_in.rp    = rp_ff + 1'b1;
               cm_in.sp    = sp_ff - 1'b1;
            end
            OP_POP: begin
               cm_in.ds0_we = 1'b1;
               cm_in.ds0_a  = sp_ff + 1'b1;
               cm_in.ds0_d  = r_ff;
               cm_in.sp     = sp_ff + 1'b1;
               cm_in.rp     = rp_ff - 1'b1;
            end
            OP_JUMP, OP_CALL: begin
               if (!addr_ok(t_ff)) begin
                  flt = FLT_BAD_ADDR;
               end else begin
                  if (op == OP_CALL) begin
                     cm_in.rs_we = 1'b1;
                     cm_in.rs_a  = rp_ff + 1'b1;
                     cm_in.rs_d  = CELL_BITS'(pc_ff);
                     cm_in.rp    = rp_ff + 1'b1;
                  end
                  cm_in.sp = sp_ff - 1'b1;
                  nxt      = {1'b0, t_ff[MEM_AW-1:0]};
               end
            end
            OP_IF: begin
               if (!addr_ok(if_target)) begin
                  flt = FLT_BAD_ADDR;
               end else begin
                  cm_in.rs_we = 1'b1;
                  cm_in.rs_a  = rp_ff + 1'b1;
                  cm_in.rs_d  = CELL_BITS'(pc_ff);
                  cm_in.rp    = rp_ff + 1'b1;
                  cm_in.sp    = sp_ff - DS_AW'(3);
                  nxt         = {1'b0, if_target[MEM_AW-1:0]};
               end
            end
            OP_RET: begin
               if (!addr_ok(ret_target)) begin
                  flt = FLT_BAD_ADDR;
               end else begin
                  cm_in.rp = rp_ff - 1'b1;
                  nxt      = {1'b0, ret_target[MEM_AW-1:0]};
               end
            end
            OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR,
            OP_XOR: begin
               cm_in.ds0_we = 1'b1;
               cm_in.ds0_a  = sp_ff - 1'b1;
               cm_in.ds0_d  = alu_res;
               cm_in.sp     = sp_ff - 1'b1;
            end
            OP_FETCH: begin
               if (!addr_ok(t_ff)) begin
                  flt = FLT_BAD_ADDR;
               end else begin
                  cm_in.ds0_we = 1'b1;
                  cm_in.ds0_a  = sp_ff;
                  cm_in.ds0_d  = pm_q_ff;
               end
            end
            OP_STORE: begin
               if (!addr_ok(t_ff)) begin
                  flt = FLT_BAD_ADDR;
               end else begin
                  cm_in.pm_we = 1'b1;
                  cm_in.pm_a  = t_ff[MEM_AW-1:0];
                  cm_in.pm_d  = n_ff;
                  cm_in.sp    = sp_ff - DS_AW'(2);
               end
            end
            OP_DIVMOD: begin
               if (t_ff == '0) begin
                  flt = FLT_DIV_ZERO;
               end else begin
                  div_go = (state_ff == S_EXEC);
               end
            end
            OP_ZRET: begin
               if (t_ff == '0) begin
                  if (rp_ff == '0) begin
                     flt = FLT_RET_UNDER;
                  end else if (!addr_ok(ret_target)) begin
                     flt = FLT_BAD_ADDR;
                  end else begin
                     cm_in.sp = sp_ff - 1'b1;
                     cm_in.rp = rp_ff - 1'b1;
                     nxt      = {1'b0, ret_target[MEM_AW-1:0]};
                  end
               end
            end
            OP_END: begin
               end_hit    = 1'b1;
               cm_in.stop = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (flt != FLT_NONE) begin
         cm_in       = '0;
         cm_in.sp    = sp_ff;
         cm_in.rp    = rp_ff;
         cm_in.pc    = pc_ff;
         cm_in.stop  = 1'b1;
         cm_in.fault = flt;
      end else if (!end_hit) begin
         if (nxt[MEM_AW]) begin
            cm_in.stop = 1'b1;
         end else begin
            cm_in.pc = nxt[MEM_AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= '0;
         sp_ff        <= '0;
         rp_ff        <= '0;
         stop_ff      <= 1'b0;
         fault_ff     <= FLT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == MEM_AW'(MEM_WORDS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  rep_op_ff <= '0;
                  if (req_tuser[0] && !stop_ff) begin
                     state_ff <= S_FETCH;
                  end else begin
                     state_ff <= S_TOP;
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               w_ff      <= pm_q_ff;
               rep_op_ff <= pm_q_ff[4:0];
               t_ff      <= t_dec;
               n_ff      <= (sp_ff > DS_AW'(1)) ? ds_q1_ff : '0;
               r_ff      <= rs_q_ff;
               state_ff  <= S_EXEC;
            end
            S_EXEC: begin
               cm_ff    <= cm_in;
               state_ff <= div_go ? S_DIV : S_WR1;
            end
            S_DIV: begin
               if (div_done) begin
                  cm_ff.ds0_we <= 1'b1;
                  cm_ff.ds0_a  <= sp_ff;
                  cm_ff.ds0_d  <= div_quo;
                  cm_ff.ds1_we <= 1'b1;
                  cm_ff.ds1_a  <= sp_ff - 1'b1;
                  cm_ff.ds1_d  <= div_rem;
                  state_ff     <= S_WR1;
               end
            end
            S_WR1: begin
               sp_ff    <= cm_ff.sp;
               rp_ff    <= cm_ff.rp;
               pc_ff    <= cm_ff.pc;
               stop_ff  <= cm_ff.stop;
               fault_ff <= cm_ff.fault;
               state_ff <= cm_ff.ds1_we ? S_WR2 : S_TOP;
            end
            S_WR2: begin
               state_ff <= S_TOP;
            end
            S_TOP: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_word_ff.pad             <= '0;
                  rsp_word_ff.fault           <= fault_ff;
                  rsp_word_ff.halted          <= stop_ff;
                  rsp_word_ff.return_depth    <= rp_ff;
                  rsp_word_ff.data_depth      <= sp_ff;
                  rsp_word_ff.top_value       <= (sp_ff != '0) ? ds_q0_ff[31:0] : '0;
                  rsp_word_ff.executed_opcode <= rep_op_ff;
                  rsp_word_ff.program_counter <= 14'(pc_ff);
                  state_ff                    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/dsvm_checker.sv =====
// Port-level checks on the result stream of the dual stack VM core, bound to the top level.
// Depends on dsvm_pkg and dual_stack_vm_core_macros.svh.
`include "dual_stack_vm_core_macros.svh"

module dsvm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [dsvm_pkg::RSP_BITS-1:0] rsp_tdata
);
   import dsvm_pkg::*;

   rsp_word_type        rsp;
   logic                seen_halt_ff;
   logic [13:0]         last_pc_ff;
   fault_type           last_fault_ff;
   logic [RSP_BITS-1:0] prev_data_ff;
   logic                stall_ante;
   logic                held_ok;
   logic                fault_ante;
   logic                sticky_ante;
   logic                sticky_ok;
   logic                empty_ante;

   assign rsp         = rsp_word_type'(rsp_tdata);
   assign stall_ante  = rsp_tvalid && !rsp_tready;
   assign held_ok     = rsp_tvalid && (rsp_tdata == prev_data_ff);
   assign fault_ante  = rsp_tvalid && (rsp.fault != FLT_NONE);
   assign sticky_ante = rsp_tvalid && rsp_tready && seen_halt_ff;
   assign sticky_ok   = rsp.halted && (rsp.program_counter == last_pc_ff)
                        && (rsp.fault == last_fault_ff);
   assign empty_ante  = rsp_tvalid && (rsp.data_depth == '0);

   always_ff @(posedge clock) begin
      prev_data_ff <= rsp_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp.halted) begin
         seen_halt_ff  <= 1'b1;
         last_pc_ff    <= rsp.program_counter;
         last_fault_ff <= rsp.fault;
      end
   end

   `DSVM_ASSERT_NEXT(a_rsp_hold, clock, reset, stall_ante, held_ok, "stalled word changed")
   `DSVM_ASSERT_SAME(a_fault_halts, clock, reset, fault_ante, rsp.halted, "fault without halt")
   `DSVM_ASSERT_SAME(a_halt_sticky, clock, reset, sticky_ante, sticky_ok, "halted state changed")
   `DSVM_ASSERT_SAME(a_empty_top, clock, reset, empty_ante, rsp.top_value == '0, "nonzero top")

endmodule

bind dual_stack_vm_core dsvm_checker u_dsvm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/dual_stack_vm_core_checker.sv =====
`timescale 1ns / 1ps
// Checker for the dual stack VM core: watches both stream channels, predicts each result
// word from its own copy of the machine and compares it field by field. Depends on dsvm_pkg.
module dual_stack_vm_core_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [dsvm_pkg::REQ_BITS-1:0] req_tdata,
   input  logic [0:0]                    req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [dsvm_pkg::RSP_BITS-1:0] rsp_tdata,
   output int                            errors,
   output int                            pending
);
   import dsvm_pkg::*;

   logic [31:0]  prog [0:MEM_WORDS-1];
   logic [31:0]  dstk [0:DS_DEPTH-1];
   logic [31:0]  rstk [0:RS_DEPTH-1];
   int           dptr;
   int           rptr;
   int           pc;
   logic         stop;
   fault_type    flt;
   rsp_word_type expected_q [$];
   int           err_count;

   assign errors = err_count;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      err_count++;
   endtask

   task automatic halt_with(input fault_type f);
      stop = 1'b1;
      flt  = f;
   endtask

   function automatic logic in_memory(input logic [31:0] v);
      return v < 32'(MEM_WORDS);
   endfunction

   task automatic execute();
      logic [31:0] w, t, n, a, q, rm;
      int          nxt, need;
      opcode_type  op;
      w   = prog[pc];
      nxt = pc + 1;
      t   = '0;
      n   = '0;
      if (w > 32'(LAST_OP)) begin
         halt_with(FLT_BAD_OP);
         return;
      end
      op = opcode_type'(w[4:0]);
      case (op)
         OP_DUP, OP_DROP, OP_PUSH, OP_JUMP, OP_CALL, OP_FETCH, OP_ZRET: need = 1;
         OP_SWAP, OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_STORE, OP_ADD, OP_SUB, OP_MUL,
         OP_DIVMOD, OP_AND, OP_OR, OP_XOR: need = 2;
         OP_IF: need = 3;
         default: need = 0;
      endcase
      if (dptr < need) begin
         halt_with(FLT_DATA_UNDER);
         return;
      end
      if ((op == OP_LIT || op == OP_DUP || op == OP_POP) && dptr + 1 > DS_DEPTH - 1) begin
         halt_with(FLT_DATA_OVER);
         return;
      end
      if ((op == OP_POP || op == OP_RET) && rptr == 0) begin
         halt_with(FLT_RET_UNDER);
         return;
      end
      if ((op == OP_PUSH || op == OP_CALL || op == OP_IF) && rptr + 1 > RS_DEPTH - 1) begin
         halt_with(FLT_RET_OVER);
         return;
      end
      if (dptr >= 1) t = dstk[dptr];
      if (dptr >= 2) n = dstk[dptr-1];
      case (op)
         OP_LIT: begin
            if (nxt >= MEM_WORDS) begin
               halt_with(FLT_BAD_ADDR);
               return;
            end
            dstk[dptr+1] = prog[nxt];
            dptr++;
            nxt++;
         end
         OP_DUP: begin
            dstk[dptr+1] = t;
            dptr++;
         end
         OP_DROP: dptr--;
         OP_SWAP: begin
            dstk[dptr]   = n;
            dstk[dptr-1] = t;
         end
         OP_PUSH: begin
            rstk[rptr+1] = t;
            rptr++;
            dptr--;
         end
         OP_POP: begin
            dstk[dptr+1] = rstk[rptr];
            dptr++;
            rptr--;
         end
         OP_JUMP, OP_CALL: begin
            if (!in_memory(t)) begin
               halt_with(FLT_BAD_ADDR);
               return;
            end
            if (op == OP_CALL) begin
               rstk[rptr+1] = 32'(pc);
               rptr++;
            end
            dptr--;
            nxt = int'(t);
         end
         OP_IF: begin
            a = (dstk[dptr-2] != 0) ? n : t;
            if (!in_memory(a)) begin
               halt_with(FLT_BAD_ADDR);
               return;
            end
            rstk[rptr+1] = 32'(pc);
            rptr++;
            dptr -= 3;
            nxt = int'(a);
         end
         OP_RET: begin
            a = rstk[rptr] + 32'd1;
            if (!in_memory(a)) begin
               halt_with(FLT_BAD_ADDR);
               return;
            end
            rptr--;
            nxt = int'(a);
         end
         OP_EQ, OP_NEQ, OP_LT, OP_GT: begin
            case (op)
               OP_EQ:   a = (n == t) ? '1 : '0;
               OP_NEQ:  a = (n != t) ? '1 : '0;
               OP_LT:   a = ($signed(n) < $signed(t)) ? '1 : '0;
               default: a = ($signed(t) < $signed(n)) ? '1 : '0;
            endcase
            dstk[dptr-1] = a;
            dptr--;
         end
         OP_FETCH: begin
            if (!in_memory(t)) begin
               halt_with(FLT_BAD_ADDR);
               return;
            end
            dstk[dptr] = prog[t[13:0]];
         end
         OP_STORE: begin
            if (!in_memory(t)) begin
               halt_with(FLT_BAD_ADDR);
               return;
            end
            prog[t[13:0]] = n;
            dptr -= 2;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: begin
            case (op)
               OP_ADD:  a = n + t;
               OP_SUB:  a = n - t;
               OP_MUL:  a = n * t;
               OP_AND:  a = n & t;
               OP_OR:   a = n | t;
               default: a = n ^ t;
            endcase
            dstk[dptr-1] = a;
            dptr--;
         end
         OP_DIVMOD: begin
            if (t == 0) begin
               halt_with(FLT_DIV_ZERO);
               return;
            end
            if (n == 32'h8000_0000 && t == 32'hFFFF_FFFF) begin
               q  = n;
               rm = '0;
            end else begin
               q  = $signed(n) / $signed(t);
               rm = $signed(n) % $signed(t);
            end
            dstk[dptr]   = q;
            dstk[dptr-1] = rm;
         end
         OP_ZRET: begin
            if (t == 0) begin
               if (rptr == 0) begin
                  halt_with(FLT_RET_UNDER);
                  return;
               end
               a = rstk[rptr] + 32'd1;
               if (!in_memory(a)) begin
                  halt_with(FLT_BAD_ADDR);
                  return;
               end
               dptr--;
               rptr--;
               nxt = int'(a);
            end
         end
         OP_END: begin
            stop = 1'b1;
            return;
         end
         default: ;
      endcase
      if (nxt >= MEM_WORDS) stop = 1'b1;
      else pc = nxt;
   endtask

   task automatic take_word(input logic kind, input req_word_type w);
      rsp_word_type e;
      logic [4:0]   opc;
      opc = '0;
      if (!kind) begin
         prog[w.load_address] = w.load_value;
      end else if (!stop) begin
         opc = prog[pc][4:0];
         execute();
      end
      e = '0;
      e.program_counter = 14'(pc);
      e.executed_opcode = opc;
      e.top_value       = (dptr != 0) ? dstk[dptr] : '0;
      e.data_depth      = DS_AW'(dptr);
      e.return_depth    = RS_AW'(rptr);
      e.halted          = stop;
      e.fault           = flt;
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         for (int i = 0; i < MEM_WORDS; i++) prog[i] = '0;
         for (int i = 0; i < DS_DEPTH; i++) dstk[i] = '0;
         for (int i = 0; i < RS_DEPTH; i++) rstk[i] = '0;
         dptr = 0;
         rptr = 0;
         pc   = 0;
         stop = 1'b0;
         flt  = FLT_NONE;
         expected_q.delete();
         err_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (expected_q.size() == 0) begin
               $display("result word with no expectation waiting: %0h", rsp_tdata);
               err_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.program_counter != want.program_counter)
                  report("program_counter", got.program_counter, want.program_counter);
               if (got.executed_opcode != want.executed_opcode)
                  report("executed_opcode", got.executed_opcode, want.executed_opcode);
               if (got.top_value != want.top_value)
                  report("top_value", got.top_value, want.top_value);
               if (got.data_depth != want.data_depth)
                  report("data_depth", got.data_depth, want.data_depth);
               if (got.return_depth != want.return_depth)
                  report("return_depth", got.return_depth, want.return_depth);
               if (got.halted != want.halted)
                  report("halted", got.halted, want.halted);
               if (got.fault != want.fault)
                  report("fault", got.fault, want.fault);
            end
         end
         if (req_tvalid && req_tready)
            take_word(req_tuser[0], req_word_type'(req_tdata));
      end
      pending <= expected_q.size();
   end

endmodule

// ===== tb/dual_stack_vm_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the dual stack VM core testbench: clock, reset, program stimulus and the verdict.
// Depends on dsvm_pkg, dual_stack_vm_core and dual_stack_vm_core_checker.
module dual_stack_vm_core_tb;
   import dsvm_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic [0:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   int                  errors;
   int                  pending;

   int                  wp;
   int                  dd;
   logic [31:0]         ret_q [$];
   logic [31:0]         code [$];
   int                  n_steps;
   int                  items;
   int                  stall;
   opcode_type          binops [10] = '{OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_ADD, OP_SUB,
                                        OP_MUL, OP_AND, OP_OR, OP_XOR};

   dual_stack_vm_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   dual_stack_vm_core_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if ((items / 64) % 4 == 3) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall      <= 0;
      end else if (stall > 0) begin
         rsp_tready <= 1'b0;
         stall      <= stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ((items / 64) % 4 != 1 && $urandom_range(0, 99) < 20)
            stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
   end

   task automatic send(input logic kind, input logic [13:0] addr, input logic [31:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, val, addr};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      items++;
   endtask

   // Idles the request side and waits until every expected result word has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_cell();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'($urandom_range(0, 20));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic ret_ok();
      return ret_q.size() > 0 && ret_q[$] < 32'd16250;
   endfunction

   task automatic put_op(input opcode_type op);
      code.push_back(32'(op));
      n_steps++;
   endtask

   task automatic put_lit(input logic [31:0] v);
      put_op(OP_LIT);
      code.push_back(v);
   endtask

   // Loads the pending code at the write pointer, then steps through it.
   task automatic run_group();
      foreach (code[i]) send(1'b0, 14'(wp + i), code[i]);
      repeat (n_steps) send(1'b1, 14'($urandom), $urandom);
      wp += code.size();
      code.delete();
      n_steps = 0;
   endtask

   task automatic jump_to(input int target);
      put_lit(32'(target));
      put_op(OP_JUMP);
      run_group();
      wp = target;
   endtask

   task automatic random_group();
      int          dest;
      logic [31:0] v, tt, tf;
      dest = -1;
      case ($urandom_range(0, 15))
         0: if (dd <= 26) begin
            put_lit(rnd_cell());
            dd++;
         end
         1: if (dd >= 1 && dd <= 26) begin
            put_op(OP_DUP);
            dd++;
         end
         2: if (dd >= 1) begin
            put_op(OP_DROP);
            dd--;
         end
         3: if (dd >= 2) put_op(OP_SWAP);
         4: if (dd >= 2) begin
            put_op(binops[$urandom_range(0, 9)]);
            dd--;
         end
         5: if (dd >= 1 && dd <= 26) begin
            v = rnd_cell();
            if (v == 0) v = 32'd3;
            put_lit(v);
            put_op(OP_DIVMOD);
            dd++;
         end
         6: if (dd <= 26) begin
            put_lit(32'($urandom_range(0, MEM_WORDS - 1)));
            put_op(OP_FETCH);
            dd++;
         end
         7: if (dd <= 25) begin
            put_lit(rnd_cell());
            put_lit(32'($urandom_range(0, MEM_WORDS - 1)));
            put_op(OP_STORE);
         end
         8: if (ret_q.size() < 120 && dd <= 26) begin
            v = $urandom_range(0, 1) ? 32'($urandom_range(0, 16000)) : rnd_cell();
            put_lit(v);
            put_op(OP_PUSH);
            ret_q.push_back(v);
         end
         9: if (ret_q.size() > 0 && dd <= 26) begin
            put_op(OP_POP);
            void'(ret_q.pop_back());
            dd++;
         end
         10: if (dd <= 26) dest = $urandom_range(0, 16250);
         11: if (ret_q.size() < 120 && dd <= 26) begin
            dest = $urandom_range(0, 16250);
            put_lit(32'(dest));
            ret_q.push_back(32'(wp + 2));
            put_op(OP_CALL);
         end
         12: if (ret_q.size() < 120 && dd <= 24) begin
            v  = $urandom_range(0, 1) ? 32'd0 : rnd_cell();
            tt = $urandom_range(0, 16250);
            tf = $urandom_range(0, 16250);
            put_lit(v);
            put_lit(tt);
            put_lit(tf);
            put_op(OP_IF);
            ret_q.push_back(32'(wp + 6));
            dest = (v != 0) ? int'(tt) : int'(tf);
         end
         13: if (ret_ok()) begin
            put_op(OP_RET);
            dest = int'(ret_q.pop_back()) + 1;
         end
         14: if (dd <= 26) begin
            v = (ret_ok() && $urandom_range(0, 1)) ? 32'd0 : rnd_cell();
            if (v == 0 && !ret_ok()) v = 32'd1;
            put_lit(v);
            put_op(OP_ZRET);
            if (v == 0) dest = int'(ret_q.pop_back()) + 1;
         end
         default: put_op($urandom_range(0, 1) ? OP_NOP : OP_SHIFT);
      endcase
      if (dest >= 0 && n_steps == 0) begin
         jump_to(dest);
      end else begin
         if (n_steps == 0) put_op(OP_NOP);
         run_group();
         if (dest >= 0) wp = dest;
      end
   endtask

   task automatic final_halt();
      logic [31:0] v;
      jump_to(100);
      case ($urandom_range(0, 9))
         0: put_op(OP_END);
         1: begin
            while (dd > 0) begin
               put_op(OP_DROP);
               dd--;
            end
            put_op(OP_DROP);
         end
         2: begin
            while (dd < DS_DEPTH - 1) begin
               put_lit(rnd_cell());
               dd++;
            end
            put_lit(rnd_cell());
         end
         3: begin
            while (ret_q.size() > 0) begin
               if (dd >= 30) begin
                  put_op(OP_DROP);
                  dd--;
               end
               put_op(OP_POP);
               put_op(OP_DROP);
               void'(ret_q.pop_back());
            end
            put_op(OP_POP);
         end
         4: begin
            if (dd >= 30) put_op(OP_DROP);
            repeat (RS_DEPTH - ret_q.size()) begin
               put_lit(rnd_cell());
               put_op(OP_PUSH);
            end
         end
         5: begin
            v = $urandom_range(0, 1) ? 32'($urandom_range(LAST_OP + 1, 31)) : 32'h8000_0000 | $urandom;
            code.push_back(v);
            n_steps++;
         end
         6: begin
            if (dd >= 29) put_op(OP_DROP);
            put_lit(32'd5);
            put_lit(32'd0);
            put_op(OP_DIVMOD);
         end
         7: begin
            if (dd >= 30) put_op(OP_DROP);
            put_lit($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(MEM_WORDS));
            put_op($urandom_range(0, 1) ? OP_JUMP : OP_FETCH);
         end
         default: begin
            if (dd >= 30) begin
               put_op(OP_DROP);
               dd--;
            end
            jump_to(MEM_WORDS - 1);
            put_op($urandom_range(0, 1) ? OP_LIT : OP_NOP);
         end
      endcase
      run_group();
      repeat (3) send(1'b1, 14'($urandom), $urandom);
      send(1'b0, 14'($urandom), $urandom);
      send(1'b1, 14'($urandom), $urandom);
   endtask

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      wp         = 0;
      dd         = 0;
      n_steps    = 0;
      items      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send(1'b0, 14'h3FFF, 32'hFFFF_FFFF);
      send(1'b0, 14'h2AAA, 32'h8000_0000);
      send(1'b0, 14'h1555, 32'h7FFF_FFFF);
      put_lit(32'h8000_0000);
      put_lit(32'hFFFF_FFFF);
      put_op(OP_DIVMOD);
      put_lit(32'hFFFF_FFF9);
      put_lit(32'd2);
      put_op(OP_DIVMOD);
      put_op(OP_LT);
      put_op(OP_SHIFT);
      put_op(OP_NOP);
      dd = 3;
      run_group();
      drain();

      while (items < 1100) begin
         if (wp > 16250) jump_to($urandom_range(0, 16000));
         if ($urandom_range(0, 9) == 0) send(1'b0, 14'($urandom), $urandom);
         random_group();
         if (items % 300 < 8) drain();
      end
      final_halt();
      drain();

      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
